/* design/gsq_pkg.sv */
// gsq_pkg: shared types and constants for the gate sensor qualifier
`default_nettype none
package gsq_pkg;

    // tick kinds
    localparam logic OP_FAST = 1'b0;
    localparam logic OP_SLOW = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_GROUND_THRESHOLD = 3'd0,
        REG_AIR_THRESHOLD    = 3'd1,
        REG_CLOSE_DELAY      = 3'd2,
        REG_REMOTE_HOLD      = 3'd3,
        REG_LIMIT_HOLD       = 3'd4,
        REG_LOG_PERIOD       = 3'd5,
        REG_LIGHT_PERIOD     = 3'd6
    } reg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int WIDE_CNT_W  = 17;
    localparam int NARROW_CNT_W = 9;

    // reset values of the configuration registers
    localparam logic [15:0] GROUND_THRESHOLD_RST = 16'd100;
    localparam logic [15:0] AIR_THRESHOLD_RST    = 16'd5;
    localparam logic [15:0] CLOSE_DELAY_RST      = 16'd25000;
    localparam logic [7:0]  REMOTE_HOLD_RST      = 8'd20;
    localparam logic [7:0]  LIMIT_HOLD_RST       = 8'd10;
    localparam logic [15:0] LOG_PERIOD_RST       = 16'd10000;
    localparam logic [15:0] LIGHT_PERIOD_RST     = 16'd200;

    typedef struct packed {
        logic [15:0] ground_threshold;
        logic [15:0] air_threshold;
        logic [15:0] close_delay;
        logic [7:0]  remote_hold;
        logic [7:0]  limit_hold;
        logic [15:0] log_period;
        logic [15:0] light_period;
    } cfg_t;

    typedef struct packed {
        logic op;
        logic remote_pin;
        logic horizontal_pin;
        logic vertical_pin;
        logic ground_pin;
        logic air_pin;
    } item_t;

    typedef struct packed {
        logic remote_open;
        logic horizontal_reached;
        logic vertical_reached;
        logic run_dir;
        logic motor_stop;
        logic reached_top;
        logic ground_present;
        logic car_entered;
        logic entry_timeout;
        logic air_detected;
        logic log_due;
        logic light_due;
    } result_t;

endpackage
`default_nettype wire

/* design/gsq_core.sv */
// gsq_core: qualifier state and the per-tick update logic
`default_nettype none
module gsq_core (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic step,
    input  wire gsq_pkg::item_t      item,
    input  wire gsq_pkg::cfg_t       cfg,
    output gsq_pkg::result_t         result
);
    import gsq_pkg::*;

    logic remote_last_reg, remote_last_next;
    logic remote_armed_reg, remote_armed_next;
    logic remote_flag_reg, remote_flag_next;
    logic [NARROW_CNT_W-1:0] remote_count_reg, remote_count_next;
    logic hor_last_reg, hor_last_next;
    logic [NARROW_CNT_W-1:0] hor_count_reg, hor_count_next;
    logic hor_state_reg, hor_state_next;
    logic ver_last_reg, ver_last_next;
    logic [NARROW_CNT_W-1:0] ver_count_reg, ver_count_next;
    logic ver_state_reg, ver_state_next;
    logic direction_reg, direction_next;
    logic ground_last_reg, ground_last_next;
    logic [WIDE_CNT_W-1:0] ground_count_reg, ground_count_next;
    logic ground_checked_reg, ground_checked_next;
    logic close_pending_reg, close_pending_next;
    logic [WIDE_CNT_W-1:0] close_count_reg, close_count_next;
    logic air_last_reg, air_last_next;
    logic [WIDE_CNT_W-1:0] air_count_reg, air_count_next;
    logic air_checked_reg, air_checked_next;
    logic [WIDE_CNT_W-1:0] log_count_reg, log_count_next;
    logic [WIDE_CNT_W-1:0] light_count_reg, light_count_next;

    logic [NARROW_CNT_W-1:0] remote_inc, hor_inc, ver_inc;
    logic [WIDE_CNT_W-1:0] ground_inc, close_inc, air_inc, log_inc, light_inc;
    logic stop, top, entered, timeout, log_hit, light_hit;

    assign remote_inc = remote_count_reg + NARROW_CNT_W'(1);
    assign hor_inc    = hor_count_reg + NARROW_CNT_W'(1);
    assign ver_inc    = ver_count_reg + NARROW_CNT_W'(1);
    assign ground_inc = ground_count_reg + WIDE_CNT_W'(1);
    assign close_inc  = close_count_reg + WIDE_CNT_W'(1);
    assign air_inc    = air_count_reg + WIDE_CNT_W'(1);
    assign log_inc    = log_count_reg + WIDE_CNT_W'(1);
    assign light_inc  = light_count_reg + WIDE_CNT_W'(1);

    always_comb
    begin
        remote_last_next    = remote_last_reg;
        remote_armed_next   = remote_armed_reg;
        remote_flag_next    = remote_flag_reg;
        remote_count_next   = remote_count_reg;
        hor_last_next       = hor_last_reg;
        hor_count_next      = hor_count_reg;
        hor_state_next      = hor_state_reg;
        ver_last_next       = ver_last_reg;
        ver_count_next      = ver_count_reg;
        ver_state_next      = ver_state_reg;
        direction_next      = direction_reg;
        ground_last_next    = ground_last_reg;
        ground_count_next   = ground_count_reg;
        ground_checked_next = ground_checked_reg;
        close_pending_next  = close_pending_reg;
        close_count_next    = close_count_reg;
        air_last_next       = air_last_reg;
        air_count_next      = air_count_reg;
        air_checked_next    = air_checked_reg;
        log_count_next      = log_count_reg;
        light_count_next    = light_count_reg;
        stop      = 1'b0;
        top       = 1'b0;
        entered   = 1'b0;
        timeout   = 1'b0;
        log_hit   = 1'b0;
        light_hit = 1'b0;

        if (item.op == OP_FAST)
        begin
            // remote button: count only while armed, release keeps the count
            if (!item.remote_pin && !remote_last_reg)
            begin
                if (remote_armed_reg)
                begin
                    if (remote_inc > {1'b0, cfg.remote_hold})
                    begin
                        remote_flag_next  = !remote_flag_reg;
                        remote_count_next = '0;
                        remote_armed_next = 1'b0;
                    end
                    else
                    begin
                        remote_count_next = remote_inc;
                    end
                end
            end
            else
            begin
                remote_armed_next = 1'b1;
            end
            remote_last_next = item.remote_pin;

            // horizontal limit
            if (!item.horizontal_pin && !hor_last_reg)
            begin
                if (hor_inc > {1'b0, cfg.limit_hold})
                begin
                    hor_state_next = 1'b1;
                    hor_count_next = '0;
                    if (direction_reg)
                    begin
                        direction_next = 1'b0;
                        stop = 1'b1;
                    end
                end
                else
                begin
                    hor_count_next = hor_inc;
                end
            end
            else
            begin
                hor_state_next = 1'b0;
                hor_count_next = '0;
            end
            hor_last_next = item.horizontal_pin;

            // vertical limit sees the direction after the horizontal check
            if (!item.vertical_pin && !ver_last_reg)
            begin
                if (ver_inc > {1'b0, cfg.limit_hold})
                begin
                    ver_state_next = 1'b1;
                    ver_count_next = '0;
                    if (!direction_next)
                    begin
                        direction_next     = 1'b1;
                        stop               = 1'b1;
                        top                = 1'b1;
                        close_pending_next = 1'b1;
                    end
                end
                else
                begin
                    ver_count_next = ver_inc;
                end
            end
            else
            begin
                ver_state_next = 1'b0;
                ver_count_next = '0;
            end
            ver_last_next = item.vertical_pin;
        end
        else
        begin
            // vehicle loop
            if (!item.ground_pin && !ground_last_reg)
            begin
                if (!ground_checked_reg)
                begin
                    if (ground_inc > {1'b0, cfg.ground_threshold})
                    begin
                        ground_checked_next = 1'b1;
                        ground_count_next   = '0;
                    end
                    else
                    begin
                        ground_count_next = ground_inc;
                    end
                end
            end
            else
            begin
                if (ground_checked_reg)
                begin
                    close_pending_next = 1'b0;
                    entered            = 1'b1;
                end
                ground_checked_next = 1'b0;
                ground_count_next   = '0;
            end
            ground_last_next = item.ground_pin;

            // close delay, already cancelled if the vehicle just left
            if (close_pending_next)
            begin
                if (close_inc > {1'b0, cfg.close_delay})
                begin
                    close_pending_next = 1'b0;
                    close_count_next   = '0;
                    timeout            = 1'b1;
                end
                else
                begin
                    close_count_next = close_inc;
                end
            end
            else
            begin
                close_count_next = '0;
            end

            // air sensor
            if (!item.air_pin && !air_last_reg)
            begin
                if (!air_checked_reg)
                begin
                    if (air_inc > {1'b0, cfg.air_threshold})
                    begin
                        air_checked_next = 1'b1;
                        air_count_next   = '0;
                    end
                    else
                    begin
                        air_count_next = air_inc;
                    end
                end
            end
            else
            begin
                air_checked_next = 1'b0;
                air_count_next   = '0;
            end
            air_last_next = item.air_pin;

            if (log_inc > {1'b0, cfg.log_period})
            begin
                log_hit        = 1'b1;
                log_count_next = '0;
            end
            else
            begin
                log_count_next = log_inc;
            end

            if (light_inc > {1'b0, cfg.light_period})
            begin
                light_hit        = 1'b1;
                light_count_next = '0;
            end
            else
            begin
                light_count_next = light_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remote_last_reg    <= 1'b0;
            remote_armed_reg   <= 1'b0;
            remote_flag_reg    <= 1'b0;
            remote_count_reg   <= '0;
            hor_last_reg       <= 1'b0;
            hor_count_reg      <= '0;
            hor_state_reg      <= 1'b0;
            ver_last_reg       <= 1'b0;
            ver_count_reg      <= '0;
            ver_state_reg      <= 1'b0;
            direction_reg      <= 1'b0;
            ground_last_reg    <= 1'b0;
            ground_count_reg   <= '0;
            ground_checked_reg <= 1'b0;
            close_pending_reg  <= 1'b0;
            close_count_reg    <= '0;
            air_last_reg       <= 1'b0;
            air_count_reg      <= '0;
            air_checked_reg    <= 1'b0;
            log_count_reg      <= '0;
            light_count_reg    <= '0;
        end
        else if (step)
        begin
            remote_last_reg    <= remote_last_next;
            remote_armed_reg   <= remote_armed_next;
            remote_flag_reg    <= remote_flag_next;
            remote_count_reg   <= remote_count_next;
            hor_last_reg       <= hor_last_next;
            hor_count_reg      <= hor_count_next;
            hor_state_reg      <= hor_state_next;
            ver_last_reg       <= ver_last_next;
            ver_count_reg      <= ver_count_next;
            ver_state_reg      <= ver_state_next;
            direction_reg      <= direction_next;
            ground_last_reg    <= ground_last_next;
            ground_count_reg   <= ground_count_next;
            ground_checked_reg <= ground_checked_next;
            close_pending_reg  <= close_pending_next;
            close_count_reg    <= close_count_next;
            air_last_reg       <= air_last_next;
            air_count_reg      <= air_count_next;
            air_checked_reg    <= air_checked_next;
            log_count_reg      <= log_count_next;
            light_count_reg    <= light_count_next;
        end
    end

    always_comb
    begin
        result.remote_open        = remote_flag_next;
        result.horizontal_reached = hor_state_next;
        result.vertical_reached   = ver_state_next;
        result.run_dir            = direction_next;
        result.motor_stop         = stop;
        result.reached_top        = top;
        result.ground_present     = ground_checked_next;
        result.car_entered        = entered;
        result.entry_timeout      = timeout;
        result.air_detected       = air_checked_next;
        result.log_due            = log_hit;
        result.light_due          = light_hit;
    end

    // a pending close only exists once the arm has turned down at the top
    a_pending_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (step && top) |=> (close_pending_reg && direction_reg))
        else $error("close delay not started at top arrival");

    // a qualified count always restarts from zero
    a_hor_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && hor_state_next && !hor_state_reg) |=> (hor_count_reg == '0))
        else $error("horizontal count not cleared on qualify");

    a_remote_disarm: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (remote_flag_next != remote_flag_reg)) |=> !remote_armed_reg)
        else $error("remote still armed after toggle");

endmodule
`default_nettype wire

/* design/gate_sensor_qualifier.sv */
// gate_sensor_qualifier: top level with handshake stages and configuration registers
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  op, five sensor pins
//  out      output     out_valid/out_ready  twelve status and pulse flags
//  cfg      input      cfg_we               cfg_index, cfg_data (no read-back)
//
// one request per cycle sustained while the output is not stalled; a request passes
// via the input register, then the update logic in gsq_core into the result register
// reset clears all qualifier state and loads the default register values
// a stalled output holds the input register; in_ready drops only when both are full
`default_nettype none
module gate_sensor_qualifier (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [gsq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [gsq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output      logic                             in_ready,
    input  wire logic                             op,
    input  wire logic                             remote_pin,
    input  wire logic                             horizontal_pin,
    input  wire logic                             vertical_pin,
    input  wire logic                             ground_pin,
    input  wire logic                             air_pin,
    output      logic                             out_valid,
    input  wire logic                             out_ready,
    output      logic                             remote_open,
    output      logic                             horizontal_reached,
    output      logic                             vertical_reached,
    output      logic                             run_dir,
    output      logic                             motor_stop,
    output      logic                             reached_top,
    output      logic                             ground_present,
    output      logic                             car_entered,
    output      logic                             entry_timeout,
    output      logic                             air_detected,
    output      logic                             log_due,
    output      logic                             light_due
);
    import gsq_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_vld_reg;
    result_t res_reg;
    logic    res_vld_reg;
    result_t res_next;
    logic    advance;
    logic    in_take;

    assign advance  = item_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready = !item_vld_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ground_threshold <= GROUND_THRESHOLD_RST;
            cfg_reg.air_threshold    <= AIR_THRESHOLD_RST;
            cfg_reg.close_delay      <= CLOSE_DELAY_RST;
            cfg_reg.remote_hold      <= REMOTE_HOLD_RST;
            cfg_reg.limit_hold       <= LIMIT_HOLD_RST;
            cfg_reg.log_period       <= LOG_PERIOD_RST;
            cfg_reg.light_period     <= LIGHT_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_GROUND_THRESHOLD: cfg_reg.ground_threshold <= cfg_data;
                REG_AIR_THRESHOLD:    cfg_reg.air_threshold    <= cfg_data;
                REG_CLOSE_DELAY:      cfg_reg.close_delay      <= cfg_data;
                REG_REMOTE_HOLD:      cfg_reg.remote_hold      <= cfg_data[7:0];
                REG_LIMIT_HOLD:       cfg_reg.limit_hold       <= cfg_data[7:0];
                REG_LOG_PERIOD:       cfg_reg.log_period       <= cfg_data;
                REG_LIGHT_PERIOD:     cfg_reg.light_period     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                item_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= '{op: op, remote_pin: remote_pin,
                          horizontal_pin: horizontal_pin, vertical_pin: vertical_pin,
                          ground_pin: ground_pin, air_pin: air_pin};
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    gsq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (res_next)
    );

    assign out_valid          = res_vld_reg;
    assign remote_open        = res_reg.remote_open;
    assign horizontal_reached = res_reg.horizontal_reached;
    assign vertical_reached   = res_reg.vertical_reached;
    assign run_dir            = res_reg.run_dir;
    assign motor_stop         = res_reg.motor_stop;
    assign reached_top        = res_reg.reached_top;
    assign ground_present     = res_reg.ground_present;
    assign car_entered        = res_reg.car_entered;
    assign entry_timeout      = res_reg.entry_timeout;
    assign air_detected       = res_reg.air_detected;
    assign log_due            = res_reg.log_due;
    assign light_due          = res_reg.light_due;

    // both stages full and output stalled: no new request may enter
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && res_vld_reg && !out_ready) |-> !in_ready)
        else $error("request accepted while pipeline is full");

    // top arrival always turns the arm down and stops the motor
    a_top_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reached_top) |-> (motor_stop && run_dir))
        else $error("top arrival without stop or direction change");

    // fast and slow pulses never share a result
    a_pulse_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && motor_stop) |->
            !(log_due || light_due || car_entered || entry_timeout))
        else $error("fast and slow pulses in one result");

    a_entered_gone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && car_entered) |-> !ground_present)
        else $error("vehicle still present when reported entered");

endmodule
`default_nettype wire

/* sim/tb_gate_sensor_qualifier.sv */
// testbench for gate_sensor_qualifier: predicts the status flags of every tick and checks them
module tb_gate_sensor_qualifier;
    import gsq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    // index past the register list, writes to it must change nothing
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   op;
    logic                   remote_pin;
    logic                   horizontal_pin;
    logic                   vertical_pin;
    logic                   ground_pin;
    logic                   air_pin;
    logic                   out_valid;
    logic                   out_ready;
    logic                   remote_open;
    logic                   horizontal_reached;
    logic                   vertical_reached;
    logic                   run_dir;
    logic                   motor_stop;
    logic                   reached_top;
    logic                   ground_present;
    logic                   car_entered;
    logic                   entry_timeout;
    logic                   air_detected;
    logic                   log_due;
    logic                   light_due;

    gate_sensor_qualifier u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .op                 (op),
        .remote_pin         (remote_pin),
        .horizontal_pin     (horizontal_pin),
        .vertical_pin       (vertical_pin),
        .ground_pin         (ground_pin),
        .air_pin            (air_pin),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .remote_open        (remote_open),
        .horizontal_reached (horizontal_reached),
        .vertical_reached   (vertical_reached),
        .run_dir            (run_dir),
        .motor_stop         (motor_stop),
        .reached_top        (reached_top),
        .ground_present     (ground_present),
        .car_entered        (car_entered),
        .entry_timeout      (entry_timeout),
        .air_detected       (air_detected),
        .log_due            (log_due),
        .light_due          (light_due)
    );

    // predicted qualifier state
    cfg_t                    held_cfg;
    logic                    remote_last, remote_armed, remote_flag;
    logic [NARROW_CNT_W-1:0] remote_cnt, hor_cnt, ver_cnt;
    logic                    hor_last, hor_on, ver_last, ver_on, arm_down;
    logic                    ground_last, ground_on, close_armed, air_last, air_on;
    logic [WIDE_CNT_W-1:0]   ground_cnt, close_cnt, air_cnt, log_cnt, light_cnt;

    result_t awaited_status [$];
    result_t want_flags;
    int      mismatch_count;
    int      cycle_count;
    int      out_hold;
    bit      idle_on;

    // random pin runs, index 4 remote, 3 horizontal, 2 vertical, 1 ground, 0 air
    logic    pin_lvl [5];
    int      pin_left [5];
    logic    op_lvl;
    int      op_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int draw_wait();
        return idle_on ? $urandom_range(0, 4) : 0;
    endfunction

    function automatic item_t tick(logic kind, logic [4:0] pins);
        item_t it;
        it.op = kind;
        {it.remote_pin, it.horizontal_pin, it.vertical_pin, it.ground_pin, it.air_pin} = pins;
        return it;
    endfunction

    function automatic result_t qualify_tick(item_t it);
        result_t r;
        r = '0;
        if (it.op == OP_FAST)
        begin
            if (!it.remote_pin && !remote_last)
            begin
                if (remote_armed)
                begin
                    remote_cnt = remote_cnt + 1'b1;
                    if (remote_cnt > held_cfg.remote_hold)
                    begin
                        remote_flag  = !remote_flag;
                        remote_cnt   = '0;
                        remote_armed = 1'b0;
                    end
                end
            end
            else
                remote_armed = 1'b1;
            remote_last = it.remote_pin;

            if (!it.horizontal_pin && !hor_last)
            begin
                hor_cnt = hor_cnt + 1'b1;
                if (hor_cnt > held_cfg.limit_hold)
                begin
                    hor_on  = 1'b1;
                    hor_cnt = '0;
                    if (arm_down)
                    begin
                        arm_down     = 1'b0;
                        r.motor_stop = 1'b1;
                    end
                end
            end
            else
            begin
                hor_on  = 1'b0;
                hor_cnt = '0;
            end
            hor_last = it.horizontal_pin;

            // vertical sees the direction already updated by horizontal
            if (!it.vertical_pin && !ver_last)
            begin
                ver_cnt = ver_cnt + 1'b1;
                if (ver_cnt > held_cfg.limit_hold)
                begin
                    ver_on  = 1'b1;
                    ver_cnt = '0;
                    if (!arm_down)
                    begin
                        arm_down      = 1'b1;
                        r.motor_stop  = 1'b1;
                        r.reached_top = 1'b1;
                        close_armed   = 1'b1;
                    end
                end
            end
            else
            begin
                ver_on  = 1'b0;
                ver_cnt = '0;
            end
            ver_last = it.vertical_pin;
        end
        else
        begin
            if (!it.ground_pin && !ground_last)
            begin
                if (!ground_on)
                begin
                    ground_cnt = ground_cnt + 1'b1;
                    if (ground_cnt > held_cfg.ground_threshold)
                    begin
                        ground_on  = 1'b1;
                        ground_cnt = '0;
                    end
                end
            end
            else
            begin
                if (ground_on)
                begin
                    close_armed   = 1'b0;
                    r.car_entered = 1'b1;
                end
                ground_on  = 1'b0;
                ground_cnt = '0;
            end
            ground_last = it.ground_pin;

            if (close_armed)
            begin
                close_cnt = close_cnt + 1'b1;
                if (close_cnt > held_cfg.close_delay)
                begin
                    close_armed     = 1'b0;
                    close_cnt       = '0;
                    r.entry_timeout = 1'b1;
                end
            end
            else
                close_cnt = '0;

            if (!it.air_pin && !air_last)
            begin
                if (!air_on)
                begin
                    air_cnt = air_cnt + 1'b1;
                    if (air_cnt > held_cfg.air_threshold)
                    begin
                        air_on  = 1'b1;
                        air_cnt = '0;
                    end
                end
            end
            else
            begin
                air_on  = 1'b0;
                air_cnt = '0;
            end
            air_last = it.air_pin;

            log_cnt = log_cnt + 1'b1;
            if (log_cnt > held_cfg.log_period)
            begin
                r.log_due = 1'b1;
                log_cnt   = '0;
            end
            light_cnt = light_cnt + 1'b1;
            if (light_cnt > held_cfg.light_period)
            begin
                r.light_due = 1'b1;
                light_cnt   = '0;
            end
        end

        r.remote_open        = remote_flag;
        r.horizontal_reached = hor_on;
        r.vertical_reached   = ver_on;
        r.run_dir            = arm_down;
        r.ground_present     = ground_on;
        r.air_detected       = air_on;
        return r;
    endfunction

    // mostly held pin runs around the qualify thresholds, with a glitch now and then
    function automatic item_t random_tick();
        logic [4:0] pins;
        int         hold;
        if (op_left == 0)
        begin
            op_lvl  = 1'($urandom_range(0, 1));
            op_left = $urandom_range(1, 20);
        end
        op_left--;
        for (int p = 0; p < 5; p++)
        begin
            if ((p >= 2) == (op_lvl == OP_FAST))
            begin
                if (pin_left[p] == 0)
                begin
                    pin_lvl[p] = !pin_lvl[p];
                    if (p == 4)
                        hold = int'(held_cfg.remote_hold);
                    else if (p >= 2)
                        hold = int'(held_cfg.limit_hold);
                    else if (p == 1)
                        hold = int'(held_cfg.ground_threshold);
                    else
                        hold = int'(held_cfg.air_threshold);
                    if (hold > 40)
                        hold = 40;
                    pin_left[p] = pin_lvl[p] ? $urandom_range(1, 4) : $urandom_range(0, hold + 4);
                end
                else
                    pin_left[p]--;
            end
            pins[p] = pin_lvl[p];
        end
        if ($urandom_range(0, 15) == 0)
        begin
            hold       = $urandom_range(0, 4);
            pins[hold] = ~pins[hold];
        end
        return tick(op_lvl, pins);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_flag(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s got %b expected %b", name, got, want));
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_tick(input item_t it);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        op             <= it.op;
        remote_pin     <= it.remote_pin;
        horizontal_pin <= it.horizontal_pin;
        vertical_pin   <= it.vertical_pin;
        ground_pin     <= it.ground_pin;
        air_pin        <= it.air_pin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        awaited_status.push_back(qualify_tick(it));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // writes every register, 8-bit ones with junk in the upper byte, plus the spare index
    task automatic program_regs(input cfg_t c);
        logic [2:0]  idx;
        logic [15:0] word;
        for (int i = 0; i <= REG_SPARE; i++)
        begin
            idx  = 3'(i);
            word = 16'($urandom);
            case (idx)
                REG_GROUND_THRESHOLD: word      = c.ground_threshold;
                REG_AIR_THRESHOLD:    word      = c.air_threshold;
                REG_CLOSE_DELAY:      word      = c.close_delay;
                REG_REMOTE_HOLD:      word[7:0] = c.remote_hold;
                REG_LIMIT_HOLD:       word[7:0] = c.limit_hold;
                REG_LOG_PERIOD:       word      = c.log_period;
                REG_LIGHT_PERIOD:     word      = c.light_period;
                default: ;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= word;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        held_cfg = c;
        @(negedge clk);
    endtask

    function automatic cfg_t random_cfg(int span);
        cfg_t c;
        c.ground_threshold = 16'($urandom_range(0, span));
        c.air_threshold    = 16'($urandom_range(0, span));
        c.close_delay      = 16'($urandom_range(1, span + 1));
        c.remote_hold      = 8'($urandom_range(0, span));
        c.limit_hold       = 8'($urandom_range(0, span));
        c.log_period       = 16'($urandom_range(1, span + 1));
        c.light_period     = 16'($urandom_range(1, span + 1));
        return c;
    endfunction

    task automatic run_random(input int count, input bit vary_idle);
        for (int i = 0; i < count; i++)
        begin
            if (vary_idle && (i % 50 == 0))
                idle_on = ($urandom_range(0, 3) != 0);
            send_tick(random_tick());
        end
        wait_idle();
    endtask

    task automatic test_reset_values();
        idle_on = 1'b1;
        send_tick(tick(OP_FAST, 5'b11111));
        send_tick(tick(OP_FAST, 5'b00000));
        send_tick(tick(OP_SLOW, 5'b00000));
        wait_idle();
    endtask

    task automatic test_remote_and_limits();
        cfg_t c;
        c = held_cfg;
        c.remote_hold = 8'd1;
        c.limit_hold  = 8'd0;
        program_regs(c);
        send_tick(tick(OP_FAST, 5'b11111));
        send_tick(tick(OP_FAST, 5'b01111));
        send_tick(tick(OP_FAST, 5'b01111));
        // release mid-count keeps the count
        send_tick(tick(OP_FAST, 5'b11111));
        send_tick(tick(OP_FAST, 5'b01111));
        send_tick(tick(OP_FAST, 5'b01111));
        // still held after the toggle, needs a release first
        send_tick(tick(OP_FAST, 5'b01111));
        send_tick(tick(OP_FAST, 5'b00011));
        // both limits qualify in the same tick
        send_tick(tick(OP_FAST, 5'b00000));
        send_tick(tick(OP_FAST, 5'b00000));
        send_tick(tick(OP_FAST, 5'b11111));
        wait_idle();
    endtask

    task automatic test_loop_and_strobes();
        cfg_t c;
        c = held_cfg;
        c.ground_threshold = 16'd1;
        c.air_threshold    = 16'd0;
        c.close_delay      = 16'd2;
        c.log_period       = 16'd1;
        c.light_period     = 16'd20;
        program_regs(c);
        // close delay still running from the last top arrival
        send_tick(tick(OP_SLOW, 5'b00000));
        send_tick(tick(OP_SLOW, 5'b00000));
        send_tick(tick(OP_SLOW, 5'b00000));
        send_tick(tick(OP_FAST, 5'b10111));
        send_tick(tick(OP_FAST, 5'b10111));
        send_tick(tick(OP_FAST, 5'b11011));
        send_tick(tick(OP_FAST, 5'b11011));
        // vehicle leaves the loop and cancels the close delay
        send_tick(tick(OP_SLOW, 5'b11111));
        send_tick(tick(OP_SLOW, 5'b11110));
        send_tick(tick(OP_SLOW, 5'b11100));
        wait_idle();
        // period lowered below the running count
        c.light_period = 16'd1;
        program_regs(c);
        send_tick(tick(OP_SLOW, 5'b11111));
        wait_idle();
    endtask

    task automatic test_config_extremes();
        cfg_t c;
        c = '1;
        program_regs(c);
        run_random(40, 1'b1);
        c.ground_threshold = '0;
        c.air_threshold    = '0;
        c.close_delay      = 16'd1;
        c.remote_hold      = '0;
        c.limit_hold       = '0;
        c.log_period       = 16'd1;
        c.light_period     = 16'd1;
        program_regs(c);
        idle_on = 1'b0;
        run_random(100, 1'b0);
        run_random(150, 1'b1);
    endtask

    task automatic test_random_settings();
        int spans [4];
        spans = '{3, 8, 20, 40};
        foreach (spans[k])
        begin
            program_regs(random_cfg(spans[k]));
            run_random(315, 1'b1);
        end
    endtask

    // result checker; the request side of the handshake is driven by send_tick above
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            out_hold = draw_wait();
            if (awaited_status.size() == 0)
                report_mismatch("result with no tick waiting");
            else
            begin
                want_flags = awaited_status.pop_front();
                check_flag("remote_open", remote_open, want_flags.remote_open);
                check_flag("horizontal_reached", horizontal_reached,
                           want_flags.horizontal_reached);
                check_flag("vertical_reached", vertical_reached, want_flags.vertical_reached);
                check_flag("run_dir", run_dir, want_flags.run_dir);
                check_flag("motor_stop", motor_stop, want_flags.motor_stop);
                check_flag("reached_top", reached_top, want_flags.reached_top);
                check_flag("ground_present", ground_present, want_flags.ground_present);
                check_flag("car_entered", car_entered, want_flags.car_entered);
                check_flag("entry_timeout", entry_timeout, want_flags.entry_timeout);
                check_flag("air_detected", air_detected, want_flags.air_detected);
                check_flag("log_due", log_due, want_flags.log_due);
                check_flag("light_due", light_due, want_flags.light_due);
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_ready <= 1'b0;
            out_hold--;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        op             = OP_FAST;
        remote_pin     = 1'b1;
        horizontal_pin = 1'b1;
        vertical_pin   = 1'b1;
        ground_pin     = 1'b1;
        air_pin        = 1'b1;
        out_ready      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        out_hold       = 0;
        idle_on        = 1'b1;

        held_cfg.ground_threshold = GROUND_THRESHOLD_RST;
        held_cfg.air_threshold    = AIR_THRESHOLD_RST;
        held_cfg.close_delay      = CLOSE_DELAY_RST;
        held_cfg.remote_hold      = REMOTE_HOLD_RST;
        held_cfg.limit_hold       = LIMIT_HOLD_RST;
        held_cfg.log_period       = LOG_PERIOD_RST;
        held_cfg.light_period     = LIGHT_PERIOD_RST;
        {remote_last, remote_armed, remote_flag} = '0;
        {hor_last, hor_on, ver_last, ver_on, arm_down} = '0;
        {ground_last, ground_on, close_armed, air_last, air_on} = '0;
        {remote_cnt, hor_cnt, ver_cnt} = '0;
        {ground_cnt, close_cnt, air_cnt, log_cnt, light_cnt} = '0;
        for (int p = 0; p < 5; p++)
        begin
            pin_lvl[p]  = 1'b1;
            pin_left[p] = 0;
        end
        op_lvl  = OP_FAST;
        op_left = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_values();
        test_remote_and_limits();
        test_loop_and_strobes();
        test_config_extremes();
        test_random_settings();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
